// ----- hdl/affine_angle_transform_defines.svh -----
// Assertion macros used by the port checker file
`ifndef AFFINE_ANGLE_TRANSFORM_DEFINES_SVH
`define AFFINE_ANGLE_TRANSFORM_DEFINES_SVH
// Implication checked at every rising clock edge outside reset
`define AAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define AAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/aat_pkg.sv -----
// Package: widths, stage counts and the arctangent table
`default_nettype none
package aat_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int COEF_BITS = 8 + COEF_FRAC_BITS;
  localparam int NREG = 4;
  localparam int ADDR_BITS = 4;
  localparam int XW = 34;
  localparam int VW = 62;
  localparam int DEPTH = 2 * CORDIC_STAGES + 4;

  localparam logic [1:0] REG_XX = 2'd0;
  localparam logic [1:0] REG_XY = 2'd1;
  localparam logic [1:0] REG_YX = 2'd2;
  localparam logic [1:0] REG_YY = 2'd3;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    coef_t xx;
    coef_t xy;
    coef_t yx;
    coef_t yy;
  } coef_set_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933405;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335086;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;       5'd21: r = 32'd325;
      5'd22: r = 32'd162;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [31:0] z);
    logic [31:0] t;
    t = z + (32'd1 << (31 - ANGLE_BITS));
    return t[31 -: ANGLE_BITS];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/affine_angle_transform.sv -----
// Top level: pipelined CORDIC direction transform through a 2x2 matrix
//  channel | ports                         | handshake
//  in      | in_angle                      | in_valid / in_stall
//  out     | out_angle, out_frame_*        | out_valid / out_stall
//  cfg     | psel..pready, paddr, pwdata   | APB read/write, 4 registers
// One request per cycle unless the output stalls; stages in order: the fold,
// the rotation CORDIC chain (one stage per iteration), the multiply stage,
// the sum and vectoring fold stage, the vectoring chain and the output register.
// Reset restores identity coefficients and empties the pipeline.
// A stall freezes every stage; the frame terms are formed per request from
// the coefficients held at acceptance.
`default_nettype none
module affine_angle_transform (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [aat_pkg::ANGLE_BITS-1:0] in_angle,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [aat_pkg::ANGLE_BITS-1:0] out_angle,
  output logic [aat_pkg::ANGLE_BITS-1:0] out_frame_rotation,
  output logic out_frame_mirrored,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [aat_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import aat_pkg::*;
  localparam int N = CORDIC_STAGES;

  coef_set_t coef_r;
  logic adv;
  logic [1:0] ridx;
  coef_t rsel;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];

  always_comb begin
    unique case (ridx)
      REG_XX: rsel = coef_r.xx;
      REG_XY: rsel = coef_r.xy;
      REG_YX: rsel = coef_r.yx;
      default: rsel = coef_r.yy;
    endcase
  end
  assign cfg_prdata = {{(32-COEF_BITS){rsel[COEF_BITS-1]}}, rsel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.xx <= coef_t'(1 << COEF_FRAC_BITS);
      coef_r.xy <= '0;
      coef_r.yx <= '0;
      coef_r.yy <= coef_t'(1 << COEF_FRAC_BITS);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (ridx)
        REG_XX: coef_r.xx <= cfg_pwdata[COEF_BITS-1:0];
        REG_XY: coef_r.xy <= cfg_pwdata[COEF_BITS-1:0];
        REG_YX: coef_r.yx <= cfg_pwdata[COEF_BITS-1:0];
        default: coef_r.yy <= cfg_pwdata[COEF_BITS-1:0];
      endcase
    end
  end

  // valid bits per stage
  logic [DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end
  assign out_valid = vld_r[DEPTH-1];

  // stage 0: fold, rotation CORDIC starts; coefficients travel along
  logic signed [XW-1:0] rx_r [0:N];
  logic signed [XW-1:0] ry_r [0:N];
  logic signed [33:0]   rz_r [0:N];
  coef_set_t            rc_r [0:N];

  logic [31:0] a0;
  assign a0 = {in_angle, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (a0[31:30] == 2'b01 || a0[31:30] == 2'b10) begin
        rx_r[0] <= -(XW'(1) <<< 26);
        rz_r[0] <= 34'(signed'(a0 + 32'h8000_0000));
      end else begin
        rx_r[0] <= XW'(1) <<< 26;
        rz_r[0] <= 34'(signed'(a0));
      end
      ry_r[0] <= '0;
      rc_r[0] <= coef_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic [31:0] at;
    assign at = atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rz_r[i][33]) begin
          rx_r[i+1] <= rx_r[i] - (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] + (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] - 34'(at);
        end else begin
          rx_r[i+1] <= rx_r[i] + (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] - (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] + 34'(at);
        end
        rc_r[i+1] <= rc_r[i];
      end
    end
  end

  // multiply stage: four vector products and two determinant products, then sums and frame prep
  logic signed [VW-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [2*COEF_BITS-1:0] d1_r, d2_r;
  coef_set_t mc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xx_r <= VW'(rx_r[N] * rc_r[N].xx);
      p_xy_r <= VW'(ry_r[N] * rc_r[N].xy);
      p_yx_r <= VW'(rx_r[N] * rc_r[N].yx);
      p_yy_r <= VW'(ry_r[N] * rc_r[N].yy);
      d1_r <= rc_r[N].xx * rc_r[N].yy;
      d2_r <= rc_r[N].xy * rc_r[N].yx;
      mc_r <= rc_r[N];
    end
  end

  // vectoring start: fold to right half plane, zero vector detect, mirror flag
  logic signed [VW-1:0] vx_r [0:N];
  logic signed [VW-1:0] vy_r [0:N];
  logic [31:0] vz_r [0:N];
  logic vzero_r [0:N];
  logic signed [VW-1:0] fx_r [0:N];
  logic signed [VW-1:0] fy_r [0:N];
  logic [31:0] fz_r [0:N];
  logic fzero_r [0:N];
  logic mir_r [0:N];

  logic signed [VW-1:0] sx, sy, cxs, cys;
  always_comb begin
    sx = p_xx_r + p_xy_r;
    sy = p_yx_r + p_yy_r;
    cxs = VW'(mc_r.xy) <<< (56 - COEF_BITS);
    cys = VW'(mc_r.yy) <<< (56 - COEF_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vzero_r[0] <= (sx == 0) && (sy == 0);
      vx_r[0] <= sx[VW-1] ? -sx : sx;
      vy_r[0] <= sx[VW-1] ? -sy : sy;
      vz_r[0] <= sx[VW-1] ? 32'h8000_0000 : 32'h0;
      fzero_r[0] <= (cxs == 0) && (cys == 0);
      fx_r[0] <= cxs[VW-1] ? -cxs : cxs;
      fy_r[0] <= cxs[VW-1] ? -cys : cys;
      fz_r[0] <= cxs[VW-1] ? 32'h8000_0000 : 32'h0;
      mir_r[0] <= d1_r < d2_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic [31:0] at;
    assign at = atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vy_r[i][VW-1]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + at;
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - at;
        end
        if (!fy_r[i][VW-1]) begin
          fx_r[i+1] <= fx_r[i] + (fy_r[i] >>> i);
          fy_r[i+1] <= fy_r[i] - (fx_r[i] >>> i);
          fz_r[i+1] <= fz_r[i] + at;
        end else begin
          fx_r[i+1] <= fx_r[i] - (fy_r[i] >>> i);
          fy_r[i+1] <= fy_r[i] + (fx_r[i] >>> i);
          fz_r[i+1] <= fz_r[i] - at;
        end
        vzero_r[i+1] <= vzero_r[i];
        fzero_r[i+1] <= fzero_r[i];
        mir_r[i+1] <= mir_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle <= vzero_r[N] ? '0 : round_angle(vz_r[N]);
      out_frame_rotation <= round_angle((fzero_r[N] ? 32'h0 : fz_r[N]) - 32'h4000_0000);
      out_frame_mirrored <= mir_r[N];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/aat_checker.sv -----
// Port checker for the direction transform, bound to the top level
`default_nettype none
`include "affine_angle_transform_defines.svh"
module aat_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [15:0] out_angle
);
  `AAT_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `AAT_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_angle))
  `AAT_ASSERT_NEXT(a_no_stall_when_free, !out_valid, !in_stall || out_valid)
endmodule
bind affine_angle_transform aat_checker u_aat_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_angle(out_angle)
);
`default_nettype wire
